>>> rtl/psfc_pkg.sv
// Package for the PCM sample format converter: types, register indexes
// and a decode helper. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package psfc_pkg;

  localparam int WordW = 32;
  localparam int SumW  = 36;

  typedef enum logic [2:0] {
    REG_BYTES    = 3'd0,
    REG_CHANNELS = 3'd1,
    REG_PACKED   = 3'd2,
    REG_MIX      = 3'd3,
    REG_SELECT   = 3'd4,
    REG_FORMAT   = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    MIX_PASS   = 2'd0,
    MIX_AVG    = 2'd1,
    MIX_SELECT = 2'd2,
    MIX_SPARE  = 2'd3
  } mix_t;

  // Back end sequencing.
  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_NORM, ST_ROUND, ST_DONE
  } back_st_t;

  localparam logic [4:0] FmtFloat = 5'd17;

  // Task from front to back: a finished value and the divisor to apply.
  typedef struct packed {
    logic signed [SumW-1:0] value;
    logic [4:0]             divisor;
  } task_t;

  // Decode one word to signed fixed point with 2^23 full scale.
  function automatic logic signed [SumW-1:0] decode_word(
    input logic [WordW-1:0] w, input logic [2:0] bps, input logic packed_src);
    logic [2:0]  b;
    logic [7:0]  e;
    logic [23:0] mant;
    logic [35:0] mag;
    logic signed [SumW-1:0] r;
    b = (bps == 3'd0) ? 3'd1 : ((bps > 3'd4) ? 3'd4 : bps);
    mant = {1'b1, w[22:0]};
    e = w[30:23];
    mag = '0;
    r = '0;
    if (packed_src && b != 3'd4) begin
      if (b == 3'd1)      r = SumW'(signed'(w << 16));
      else if (b == 3'd2) r = SumW'(signed'(w << 8));
      else                r = SumW'(signed'(w));
    end else if (b == 3'd1) begin
      r = SumW'(signed'({1'b0, w[7:0]}) - 10'sd128) <<< 16;
    end else if (b == 3'd2) begin
      r = SumW'(signed'(w[15:0])) <<< 8;
    end else if (b == 3'd3) begin
      r = SumW'(signed'(w[23:0]));
    end else begin
      if (e == 8'hFF) begin
        mag = (w[22:0] != '0) ? 36'd0 : 36'hFFFFFFFFF;
      end else if (e == 8'd0) begin
        mag = '0;
      end else if (e < 8'd127) begin
        mag = ((8'd127 - e) >= 8'd24) ? 36'd0 : (36'(mant) >> (8'd127 - e));
      end else if ((e - 8'd127) <= 8'd8) begin
        mag = 36'(mant) << (e - 8'd127);
      end else begin
        mag = 36'hFFFFFFFFF;
      end
      if (w[31]) begin
        if (mag > 36'h80000000) mag = 36'h80000000;
        r = -signed'(mag);
      end else begin
        if (mag > 36'h7FFFFFFF) mag = 36'h7FFFFFFF;
        r = signed'(mag);
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/psfc_front.sv
// Front end: decode, frame accumulation and channel select.
// Depends on psfc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module psfc_front #(
  parameter int MaxChannels = 8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_take,
  input  wire logic [31:0]         in_word,
  input  wire logic                cfg_hit,
  input  wire logic [2:0]          bps,
  input  wire logic                packed_src,
  input  wire logic [1:0]          mix,
  input  wire logic [3:0]          chan_cnt,
  input  wire logic [3:0]          sel_chan,
  output psfc_pkg::task_t          task_o,
  output logic                     task_valid
);
  import psfc_pkg::*;

  localparam int IdxW = (MaxChannels > 1) ? $clog2(MaxChannels) : 1;

  logic signed [SumW-1:0] sum_r, sum_nxt;
  logic [IdxW-1:0]        idx_r, idx_nxt;
  logic signed [SumW-1:0] val;
  logic [4:0]             cnt, sel;
  logic                   last;

  always_comb begin
    val = decode_word(in_word, bps, packed_src);
    cnt = (chan_cnt == 4'd0) ? 5'd1 :
          ((5'(chan_cnt) > 5'(MaxChannels)) ? 5'(MaxChannels) : 5'(chan_cnt));
    sel = (sel_chan == 4'd0) ? 5'd1 : 5'(sel_chan);
    if (sel > cnt) sel = cnt;
    sum_nxt = sum_r;
    idx_nxt = idx_r;
    task_valid = 1'b0;
    task_o.value = val;
    task_o.divisor = 5'd1;
    last = (5'(idx_r) + 5'd1) >= cnt;
    if (in_take) begin
      if (mix == MIX_AVG || mix == MIX_SELECT) begin
        if (mix == MIX_AVG) sum_nxt = sum_r + val;
        else if (5'(idx_r) + 5'd1 == sel) sum_nxt = val;
        if (last) begin
          task_valid = 1'b1;
          task_o.value = sum_nxt;
          task_o.divisor = (mix == MIX_AVG) ? cnt : 5'd1;
          sum_nxt = '0;
          idx_nxt = '0;
        end else begin
          idx_nxt = idx_r + IdxW'(1);
        end
      end else begin
        task_valid = 1'b1;
      end
    end
    if (cfg_hit) begin
      sum_nxt = '0;
      idx_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      idx_r <= '0;
    end else begin
      sum_r <= sum_nxt;
      idx_r <= idx_nxt;
    end
  end
endmodule
`default_nettype wire

>>> rtl/psfc_back.sv
// Back end: serial divide, then shift/mask or float encode.
// Depends on psfc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module psfc_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire psfc_pkg::task_t task_i,
  input  wire logic           task_valid,
  output logic                task_ready,
  input  wire logic [4:0]     fmt,
  output logic [31:0]         res_word,
  output logic                res_valid,
  input  wire logic           res_ready
);
  import psfc_pkg::*;

  back_st_t st_r, st_nxt;
  logic            neg_r;
  logic [SumW-1:0] mag_r, mag_nxt;      // dividend / quotient
  logic [4:0]      rem_r, rem_nxt;
  logic [4:0]      div_r;
  logic [5:0]      cnt_r, cnt_nxt;
  logic [5:0]      p_r, p_nxt;
  logic [31:0]     out_r, out_nxt;
  logic [5:0]      trial;
  logic signed [SumW-1:0] sval;
  logic [31:0]     u, r;
  logic [4:0]      sh;
  logic [SumW-1:0] q, rm, half;
  logic [5:0]      psh;

  assign task_ready = (st_r == ST_IDLE);
  assign res_valid  = (st_r == ST_DONE);
  assign res_word   = out_r;

  always_comb begin
    st_nxt = st_r;
    mag_nxt = mag_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    p_nxt = p_r;
    out_nxt = out_r;
    trial = {rem_r, mag_r[SumW-1]};
    sval = neg_r ? -signed'(mag_r) : signed'(mag_r);
    u = sval[31:0];
    sh = (fmt == 5'd0) ? 5'd16 : 5'(5'd16 - fmt);
    r = 32'($signed(u) >>> sh);
    psh = p_r - 6'd23;
    q = mag_r >> psh;
    rm = mag_r & ((36'd1 << psh) - 36'd1);
    half = 36'd1 << (psh - 6'd1);
    unique case (st_r)
      ST_IDLE: if (task_valid) begin
        mag_nxt = task_i.value[SumW-1] ? SumW'(-task_i.value) : SumW'(task_i.value);
        rem_nxt = '0;
        cnt_nxt = 6'(SumW);
        st_nxt = (task_i.divisor == 5'd1) ? ST_NORM : ST_DIV;
        p_nxt = 6'd35;
      end
      ST_DIV: begin
        // Restoring divide, one quotient bit per cycle.
        if (trial >= {1'b0, div_r}) begin
          rem_nxt = 5'(trial - {1'b0, div_r});
          mag_nxt = {mag_r[SumW-2:0], 1'b1};
        end else begin
          rem_nxt = trial[4:0];
          mag_nxt = {mag_r[SumW-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == 6'd1) st_nxt = ST_NORM;
      end
      ST_NORM: begin
        if (fmt < FmtFloat) begin
          if (fmt == 5'd0)      out_nxt = {24'd0, r[7:0]};
          else if (fmt <= 5'd8) out_nxt = {16'd0, r[15:0]};
          else                  out_nxt = {8'd0, r[23:0]};
          st_nxt = ST_DONE;
        end else if (mag_r == '0) begin
          out_nxt = '0;
          st_nxt = ST_DONE;
        end else if (mag_r[p_r]) begin
          st_nxt = ST_ROUND;
        end else begin
          p_nxt = p_r - 6'd1;
        end
      end
      ST_ROUND: begin
        if (p_r <= 6'd23) begin
          out_nxt = {neg_r, 8'(p_r) + 8'd104, 23'(mag_r << (6'd23 - p_r))};
        end else begin
          if (rm > half || (rm == half && q[0])) q = q + 36'd1;
          if (q[24]) begin
            out_nxt = {neg_r, 8'(p_r) + 8'd105, q[23:1]};
          end else begin
            out_nxt = {neg_r, 8'(p_r) + 8'd104, q[22:0]};
          end
        end
        st_nxt = ST_DONE;
      end
      ST_DONE: if (res_ready) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= ST_IDLE;
    else        st_r <= st_nxt;
  end

  always_ff @(posedge clk) begin
    if (st_r == ST_IDLE && task_valid) begin
      neg_r <= task_i.value[SumW-1];
      div_r <= task_i.divisor;
    end
    mag_r <= mag_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    p_r   <= p_nxt;
    out_r <= out_nxt;
  end
endmodule
`default_nettype wire

>>> rtl/psfc_queue.sv
// Two-entry task queue between front and back end.
// Depends on psfc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module psfc_queue (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire psfc_pkg::task_t wr_data,
  input  wire logic       wr_en,
  output logic            full,
  output psfc_pkg::task_t rd_data,
  output logic            rd_valid,
  input  wire logic       rd_en
);
  import psfc_pkg::*;

  task_t      mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full     = (cnt_r == 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(wr_en) - 2'(rd_en);
    end
  end
endmodule
`default_nettype wire

>>> rtl/pcm_sample_format_converter.sv
// Top level of the PCM sample format converter.
// Depends on psfc_pkg, psfc_front, psfc_queue, psfc_back.
`timescale 1ns / 1ps
`default_nettype none
// A sample word is decoded and mixed in the front end in the cycle it is
// pushed; finished values wait in a two-entry queue for the back end. The
// back end runs a bit-serial frame divide in average mode, then shifts and
// masks for integer output or runs a leading-one search and rounding for
// float output, then holds the result until popped.
// Input beats keep flowing while the queue has room; in average and select
// modes only one beat per frame reaches the queue.
module pcm_sample_format_converter #(
  parameter int MAX_CHANNELS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic [31:0] in_sample_word,
  output logic             empty,
  input  wire logic        pop,
  output logic [31:0]      out_out_word,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  import psfc_pkg::*;

  logic [2:0] bps_r;
  logic [3:0] cnt_r, sel_r;
  logic       packed_r;
  logic [1:0] mix_r;
  logic [4:0] fmt_r;
  logic       cfg_hit, take, q_full, q_valid, b_ready, f_valid, res_valid;
  task_t      f_task, q_task;

  assign cfg_ready = 1'b1;
  assign cfg_hit = cfg_valid && (cfg_index <= 3'(REG_FORMAT));
  assign full = q_full;
  assign take = push && !q_full;
  assign empty = !res_valid;

  // Hold configuration; any valid register write also clears the frame state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bps_r <= 3'd2;
      cnt_r <= 4'd2;
      packed_r <= 1'b0;
      mix_r <= MIX_PASS;
      sel_r <= 4'd1;
      fmt_r <= 5'd8;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_BYTES:    bps_r <= cfg_data[2:0];
        REG_CHANNELS: cnt_r <= cfg_data[3:0];
        REG_PACKED:   packed_r <= cfg_data[0];
        REG_MIX:      mix_r <= cfg_data[1:0];
        REG_SELECT:   sel_r <= cfg_data[3:0];
        REG_FORMAT:   fmt_r <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  psfc_front #(.MaxChannels(MAX_CHANNELS)) u_front (
    .clk, .rst_n, .in_take(take), .in_word(in_sample_word), .cfg_hit,
    .bps(bps_r), .packed_src(packed_r), .mix(mix_r), .chan_cnt(cnt_r),
    .sel_chan(sel_r), .task_o(f_task), .task_valid(f_valid)
  );

  psfc_queue u_queue (
    .clk, .rst_n, .wr_data(f_task), .wr_en(f_valid), .full(q_full),
    .rd_data(q_task), .rd_valid(q_valid), .rd_en(q_valid && b_ready)
  );

  psfc_back u_back (
    .clk, .rst_n, .task_i(q_task), .task_valid(q_valid), .task_ready(b_ready),
    .fmt(fmt_r), .res_word(out_out_word), .res_valid, .res_ready(pop)
  );
endmodule
`default_nettype wire

>>> tb/pcm_sample_format_converter_tb.sv
// Testbench for pcm_sample_format_converter: drives sample beats through the
// queue-style ports, predicts each converted word and checks it in order.
// Depends on psfc_pkg and the RTL top level.
`timescale 1ns / 1ps
module pcm_sample_format_converter_tb;
  import psfc_pkg::*;

  localparam int MaxCh = 8;
  localparam int DrainCycles = 200;
  localparam longint CycleLimit = 2000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [31:0] in_sample_word = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [31:0] out_out_word;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // Shadow of the register file and of the frame accumulator.
  logic [2:0]  sh_bytes;
  logic [3:0]  sh_channels;
  logic        sh_packed;
  logic [1:0]  sh_mix;
  logic [3:0]  sh_select;
  logic [4:0]  sh_format;
  longint      mix_sum;
  int unsigned mix_pos;

  logic [31:0] expected_words[$];
  int          error_count = 0;
  longint      cycle_count = 0;
  int          burst_left = 0;

  always #6 clk = ~clk;

  pcm_sample_format_converter #(.MAX_CHANNELS(MaxCh)) u_top (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_sample_word(in_sample_word), .empty(empty), .pop(pop),
    .out_out_word(out_out_word), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Abort on a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Float bits to fixed point, 2^23 full scale, truncated and saturated.
  function automatic longint float_bits_to_fixed(input logic [31:0] w);
    logic [7:0] ex;
    longint     mag;
    ex = w[30:23];
    if (ex == 8'hFF) begin
      if (w[22:0] != 0) return 0;
      mag = 64'hFFFFFFFFF;
    end else if (ex == 0) begin
      return 0;
    end else if (ex < 127) begin
      mag = (127 - ex >= 24) ? 0 : (longint'({1'b1, w[22:0]}) >> (127 - ex));
    end else if (ex - 127 <= 8) begin
      mag = longint'({1'b1, w[22:0]}) << (ex - 127);
    end else begin
      mag = 64'hFFFFFFFFF;
    end
    if (w[31]) begin
      if (mag > 64'h80000000) mag = 64'h80000000;
      return -mag;
    end
    if (mag > 64'h7FFFFFFF) mag = 64'h7FFFFFFF;
    return mag;
  endfunction

  function automatic longint sample_to_fixed(input logic [31:0] w);
    int unsigned b;
    logic [31:0] sh;
    b = (sh_bytes == 0) ? 1 : (sh_bytes > 4 ? 4 : sh_bytes);
    if (sh_packed && b != 4) begin
      sh = (b == 1) ? (w << 16) : (b == 2 ? (w << 8) : w);
      return longint'($signed(sh));
    end
    case (b)
      1: return (longint'(w[7:0]) - 128) * 65536;
      2: return longint'($signed(w[15:0])) * 256;
      3: return longint'($signed(w[23:0]));
      default: return float_bits_to_fixed(w);
    endcase
  endfunction

  // Fixed point back to float bits, rounding to nearest even.
  function automatic logic [31:0] fixed_to_float_bits(input longint v);
    logic        sgn;
    longint      mag, q, rem, half;
    int unsigned p, sh;
    if (v == 0) return 0;
    sgn = v < 0;
    mag = sgn ? -v : v;
    p = 0;
    while (p < 63 && (mag >> (p + 1)) != 0) p++;
    if (p <= 23) begin
      q = mag << (23 - p);
    end else begin
      sh = p - 23;
      q = mag >> sh;
      rem = mag & ((64'd1 << sh) - 1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && q[0])) q++;
      if (q >> 24 != 0) begin
        q = q >> 1;
        p++;
      end
    end
    return {sgn, 8'(p + 104), q[22:0]};
  endfunction

  function automatic logic [31:0] format_word(input longint v);
    logic [31:0] u, r;
    int unsigned sh;
    if (sh_format >= FmtFloat) return fixed_to_float_bits(v);
    u = v[31:0];
    sh = (sh_format == 0) ? 16 : 16 - sh_format;
    r = $unsigned($signed(u) >>> sh);
    if (sh_format == 0) return {24'd0, r[7:0]};
    if (sh_format <= 8) return {16'd0, r[15:0]};
    return {8'd0, r[23:0]};
  endfunction

  // Append one predicted word behind the ones still waiting.
  task automatic queue_expected(input logic [31:0] word);
    expected_words = {expected_words, word};
  endtask

  // Advance the shadow frame state for one accepted sample.
  task automatic predict_sample(input logic [31:0] w);
    longint      val;
    int unsigned cnt, sel;
    val = sample_to_fixed(w);
    cnt = (sh_channels == 0) ? 1 : (sh_channels > MaxCh ? MaxCh : sh_channels);
    sel = (sh_select == 0) ? 1 : sh_select;
    if (sel > cnt) sel = cnt;
    if (sh_mix != MIX_AVG && sh_mix != MIX_SELECT) begin
      queue_expected(format_word(val));
      return;
    end
    if (sh_mix == MIX_AVG) mix_sum += val;
    else if (mix_pos + 1 == sel) mix_sum = val;
    if (mix_pos + 1 < cnt) begin
      mix_pos++;
      return;
    end
    // longint division truncates toward zero, as the block does.
    val = (sh_mix == MIX_AVG) ? mix_sum / longint'(cnt) : mix_sum;
    mix_sum = 0;
    mix_pos = 0;
    queue_expected(format_word(val));
  endtask

  // Result side: stall on a rotating pattern, check each popped beat.
  logic [15:0] stall_pattern = 16'b1011_0000_1110_0100;
  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      if (expected_words.size() == 0) begin
        $error("out_word: unexpected beat, actual %h", out_out_word);
        error_count++;
      end else begin
        if (out_out_word !== expected_words[0]) begin
          $error("out_word: expected %h actual %h", expected_words[0], out_out_word);
          error_count++;
        end
        void'(expected_words.pop_front());
      end
    end
    stall_pattern <= {stall_pattern[14:0], stall_pattern[15]};
    if (cycle_count[11:9] == 3'd5) pop <= 1'b1;  // stretch with no stall
    else pop <= ~stall_pattern[15] | ($urandom_range(0, 3) == 0);
  end

  // Send one sample beat; gaps come between random bursts. Push stays high
  // between beats of a burst.
  task automatic send_sample(input logic [31:0] w);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) begin
        push <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    push <= 1'b1;
    in_sample_word <= w;
    do @(posedge clk); while (full);
    predict_sample(w);
  endtask

  // Drop push, wait for all results, let the back end settle.
  task automatic drain_block();
    push <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Valid stays high across back-to-back writes; set_mode drops it.
  task automatic write_reg(input reg_idx_t idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_BYTES:    sh_bytes = data[2:0];
      REG_CHANNELS: sh_channels = data[3:0];
      REG_PACKED:   sh_packed = data[0];
      REG_MIX:      sh_mix = data[1:0];
      REG_SELECT:   sh_select = data[3:0];
      default:      sh_format = data[4:0];
    endcase
    mix_sum = 0;
    mix_pos = 0;
  endtask

  task automatic set_mode(input int b, input int ch, input int pk, input mix_t mx,
                          input int sel, input int fmt);
    drain_block();
    write_reg(REG_BYTES, b);
    write_reg(REG_CHANNELS, ch);
    write_reg(REG_PACKED, pk);
    write_reg(REG_MIX, 32'(mx));
    write_reg(REG_SELECT, sel);
    write_reg(REG_FORMAT, fmt);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] random_word();
    case ($urandom_range(0, 5))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return {$urandom_range(0, 1) ? 9'h0FF : 9'h1FF, 23'($urandom)};
      3: return {1'($urandom), 8'($urandom_range(100, 140)), 23'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  // Directed: field extremes, float specials, every mix mode.
  task automatic test_directed();
    logic [31:0] specials[12] = '{32'h0, 32'hFFFFFFFF, 32'h80, 32'h7FFF, 32'h8000,
      32'h7F800000, 32'hFF800000, 32'h7FC00000, 32'h00000001, 32'h4F000000,
      32'hCF000000, 32'h3F800000};
    set_mode(4, 1, 0, MIX_PASS, 1, 17);
    foreach (specials[i]) send_sample(specials[i]);
    set_mode(1, 1, 1, MIX_PASS, 1, 0);
    send_sample(32'hFFFFFFFF); send_sample(32'h00008000);
    set_mode(2, 3, 0, MIX_AVG, 1, 16);
    repeat (3) send_sample(32'h8000);
    repeat (3) send_sample(32'h0001);
    set_mode(3, 4, 0, MIX_SELECT, 9, 9);
    repeat (4) send_sample($urandom);
    set_mode(7, 0, 1, MIX_SPARE, 0, 31);
    send_sample(32'h3F800000);
  endtask

  // Random: many register settings, extremes included.
  task automatic test_random();
    int fmt;
    for (int phase = 0; phase < 40; phase++) begin
      fmt = (phase % 8 == 0) ? 0 : (phase % 8 == 1 ? 17 : $urandom_range(0, 31));
      set_mode($urandom_range(0, 7), $urandom_range(0, 15), $urandom_range(0, 1),
               mix_t'($urandom_range(0, 3)), $urandom_range(0, 15), fmt);
      repeat (28) send_sample(random_word());
    end
  endtask

  initial begin
    sh_bytes = 2; sh_channels = 2; sh_packed = 0; sh_mix = MIX_PASS;
    sh_select = 1; sh_format = 8; mix_sum = 0; mix_pos = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random();
    drain_block();
    if (error_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule

>>> sim.f
rtl/psfc_pkg.sv
rtl/psfc_front.sv
rtl/psfc_back.sv
rtl/psfc_queue.sv
rtl/pcm_sample_format_converter.sv
tb/pcm_sample_format_converter_tb.sv
